// File: design/csa_pkg.sv
// Shared constants, widths and types of the column statistics aggregator.
package csa_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int VAL_W      = 64;
    localparam int LIMB_W     = 32;
    localparam int SUM_W      = 128;
    localparam int SQ_W       = 192;
    localparam int CNT_OUT_W  = 32;
    localparam int FRAC_OUT_W = 16;

    localparam int V_L    = VAL_W / LIMB_W;
    localparam int N_L    = (COUNT_BITS + LIMB_W - 1) / LIMB_W;
    localparam int Q_L    = SQ_W / LIMB_W;
    localparam int MAG_W  = VAL_W + COUNT_BITS;
    localparam int MAG_L  = (MAG_W + LIMB_W - 1) / LIMB_W;
    localparam int OP_L   = Q_L;
    localparam int OP_W   = OP_L * LIMB_W;
    localparam int LIDX_W = $clog2(OP_L);
    localparam int ACC_L  = Q_L + N_L;
    localparam int ACC_W  = ACC_L * LIMB_W;
    localparam int POS_W  = $clog2(2 * OP_L);

    localparam int DEN_W  = 2 * COUNT_BITS;
    localparam int NUM_W  = ACC_W + 2 * FRAC_BITS;
    localparam int R_W    = VAL_W + FRAC_BITS;
    localparam int REM_W  = (DEN_W + 1 > R_W + 3) ? DEN_W + 1 : R_W + 3;
    localparam int ITER_W = $clog2(NUM_W + 1);

    localparam logic [NUM_W-1:0] FMASK_N = (NUM_W'(1) << FRAC_BITS) - NUM_W'(1);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    has_value;
        logic                    last;
    } item_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]    count;
        logic signed [VAL_W-1:0] total;
        logic signed [VAL_W-1:0] minimum;
        logic signed [VAL_W-1:0] maximum;
        logic signed [VAL_W-1:0] mean_int;
        logic [FRAC_OUT_W-1:0]   mean_frac;
        logic [VAL_W-1:0]        var_int;
        logic [FRAC_OUT_W-1:0]   var_frac;
        logic [VAL_W-1:0]        std_int;
        logic [FRAC_OUT_W-1:0]   std_frac;
        logic                    empty_res;
        logic                    count_overflow;
    } result_t;

    typedef struct packed {
        logic              clr;
        logic              en;
        logic              sub;
        logic [POS_W-1:0]  pos;
        logic [LIMB_W-1:0] a;
        logic [LIMB_W-1:0] b;
    } mac_cmd_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: design/csa_mac.sv
// Limb multiply-accumulate unit: one 32x32 product per cycle, shifted into a wide accumulator.
module csa_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csa_pkg::mac_cmd_t         cmd,
    output logic [csa_pkg::ACC_W-1:0] acc
);
    import csa_pkg::*;

    logic [2*LIMB_W-1:0] prod_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                sub_reg;
    logic                en_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    addend;

    assign addend = ACC_W'(prod_reg) << (LIMB_W * pos_reg);
    assign acc    = acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= cmd.a * cmd.b;
        pos_reg  <= cmd.pos;
        sub_reg  <= cmd.sub;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            en_reg <= cmd.en && !cmd.clr;
            if (cmd.clr)
            begin
                acc_reg <= '0;
            end
            else if (en_reg)
            begin
                acc_reg <= sub_reg ? (acc_reg - addend) : (acc_reg + addend);
            end
        end
    end

endmodule

// File: design/csa_shsub.sv
// Bit-serial shift-subtract unit: restoring division or restoring square root.
module csa_shsub (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csa_pkg::unit_cmd_t        cmd,
    input  logic [csa_pkg::NUM_W-1:0] load,
    input  logic [csa_pkg::DEN_W-1:0] den,
    output csa_pkg::unit_stat_t       stat,
    output logic [csa_pkg::NUM_W-1:0] wk,
    output logic [csa_pkg::R_W-1:0]   root
);
    import csa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic              mode_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  wk_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [R_W-1:0]    root_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb
    begin
        if (mode_reg)
        begin
            rem_sh = {rem_reg[REM_W-3:0], wk_reg[NUM_W-1 -: 2]};
            trial  = REM_W'({root_reg, 2'b01});
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-2:0], wk_reg[NUM_W-1]};
            trial  = REM_W'(den_reg);
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = !diff[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.sqrt_mode;
                cnt_reg  <= cmd.sqrt_mode ? ITER_W'(R_W) : ITER_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            wk_reg   <= load;
            rem_reg  <= '0;
            root_reg <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : rem_sh;
            if (mode_reg)
            begin
                wk_reg   <= wk_reg << 2;
                root_reg <= {root_reg[R_W-2:0], ge};
            end
            else
            begin
                wk_reg <= {wk_reg[NUM_W-2:0], ge};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign wk        = wk_reg;
    assign root      = root_reg;

endmodule

// File: design/column_statistics_aggregator_top.sv
// Top level of the column statistics aggregator: sequencer, running statistics, result register.
//
// Usage: present one column element on item with start high; the transaction is taken at
// a rising edge where start is high and busy is low. item.has_value marks a real element,
// item.last ends the column. When a column ends, one result transaction appears on result
// with done high for exactly one cycle; the receiver cannot stall it and must take it then.
// Flow: an element transaction keeps busy high while its square is built
// from four 32x32 partial products on the shared limb multiplier, so no new element
// is taken until busy falls. A transaction without element and without last does not
// make the block busy. At an end of column the limb multiplier forms n*n, n*sum_sq
// and sum*sum, then the bit-serial shift-subtract unit runs a 256-step variance
// division, an 80-step square root and a 256-step mean division. An empty column
// passes through state S_FIN to the result register. The result is registered.
// Reset clears count, sums, overflow flag and the sequencer; after each result the block
// returns to the same cleared state for the next column.
module column_statistics_aggregator_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  csa_pkg::item_t   item,
    output logic             done,
    output csa_pkg::result_t result
);
    import csa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_FIN,
        S_DIVX,
        S_SQRT,
        S_DIVM
    } state_t;

    typedef enum logic [1:0] {
        PH_SQ,
        PH_NN,
        PH_NQ,
        PH_MM
    } phase_t;

    state_t              state_reg;
    phase_t              phase_reg;
    logic                last_reg;
    logic [LIDX_W-1:0]   ia_reg;
    logic [LIDX_W-1:0]   ib_reg;
    logic [LIDX_W-1:0]   la_reg;
    logic [LIDX_W-1:0]   lb_reg;
    logic                drain_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                ovf_reg;
    logic                done_reg;
    result_t             result_reg;

    logic [OP_W-1:0]     opa_reg;
    logic [OP_W-1:0]     opb_reg;
    logic [SQ_W-1:0]     q_reg;
    logic [DEN_W-1:0]    nsq_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_reg;
    logic [NUM_W-1:0]    x_reg;
    logic [R_W-1:0]      root_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] max_reg;

    mac_cmd_t            mcmd;
    logic [ACC_W-1:0]    acc;
    unit_cmd_t           ucmd;
    unit_stat_t          ust;
    logic [NUM_W-1:0]    uload;
    logic [DEN_W-1:0]    uden;
    logic [NUM_W-1:0]    wk;
    logic [R_W-1:0]      root;

    logic                full;
    logic                take;
    logic [VAL_W-1:0]    vbits;
    logic [VAL_W-1:0]    vmag;
    logic [SUM_W-1:0]    sum_abs;
    logic [CNT_OUT_W+32-1:0] cnt_wide;
    logic [CNT_OUT_W-1:0] cnt_sat;
    logic [NUM_W-1:0]    mq_s;
    logic [NUM_W-1:0]    var_word;
    logic                var_sat;
    result_t             res_full;
    result_t             res_empty;

    assign full    = &count_reg;
    assign take    = (state_reg == S_IDLE) && start && item.has_value && !full;
    assign vbits   = item.value;
    assign vmag    = vbits[VAL_W-1] ? (VAL_W'(0) - vbits) : vbits;
    assign sum_abs = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;

    csa_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mcmd),
        .acc   (acc)
    );

    csa_shsub u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ucmd),
        .load  (uload),
        .den   (uden),
        .stat  (ust),
        .wk    (wk),
        .root  (root)
    );

    always_comb
    begin
        mcmd     = '0;
        mcmd.en  = (state_reg == S_MUL);
        mcmd.sub = (phase_reg == PH_MM);
        mcmd.pos = POS_W'(ia_reg) + POS_W'(ib_reg);
        mcmd.a   = opa_reg[ia_reg*LIMB_W +: LIMB_W];
        mcmd.b   = opb_reg[ib_reg*LIMB_W +: LIMB_W];
        mcmd.clr = (state_reg == S_FIN)
                || ((state_reg == S_DRAIN) && drain_reg && (phase_reg == PH_NN))
                || ((state_reg == S_DIVM) && ust.done);
    end

    always_comb
    begin
        ucmd  = '0;
        uload = '0;
        uden  = '0;
        priority if ((state_reg == S_DRAIN) && drain_reg && (phase_reg == PH_MM))
        begin
            ucmd.start = 1'b1;
            uload      = NUM_W'(acc) << (2 * FRAC_BITS);
            uden       = nsq_reg;
        end
        else if ((state_reg == S_DIVX) && ust.done)
        begin
            ucmd.start     = 1'b1;
            ucmd.sqrt_mode = 1'b1;
            uload          = wk << (NUM_W - 2 * R_W);
        end
        else if ((state_reg == S_SQRT) && ust.done)
        begin
            ucmd.start = 1'b1;
            uload      = (NUM_W'(mag_reg) << FRAC_BITS)
                       + (neg_reg ? (NUM_W'(count_reg) - NUM_W'(1)) : NUM_W'(0));
            uden       = DEN_W'(count_reg);
        end
    end

    always_comb
    begin
        cnt_wide = (CNT_OUT_W+32)'(count_reg);
        cnt_sat  = (cnt_wide > (CNT_OUT_W+32)'({CNT_OUT_W{1'b1}})) ? '1
                                                                    : CNT_OUT_W'(cnt_wide);
        mq_s     = neg_reg ? (NUM_W'(0) - wk) : wk;
        var_word = x_reg >> FRAC_BITS;
        var_sat  = |(var_word >> (VAL_W + FRAC_BITS));

        res_full                = '0;
        res_full.count          = cnt_sat;
        res_full.total          = sum_reg[VAL_W-1:0];
        res_full.minimum        = min_reg;
        res_full.maximum        = max_reg;
        res_full.mean_int       = VAL_W'(mq_s >> FRAC_BITS);
        res_full.mean_frac      = FRAC_OUT_W'(mq_s & FMASK_N);
        res_full.var_int        = var_sat ? '1 : VAL_W'(var_word >> FRAC_BITS);
        res_full.var_frac       = var_sat ? FRAC_OUT_W'(FMASK_N)
                                          : FRAC_OUT_W'(var_word & FMASK_N);
        res_full.std_int        = VAL_W'(root_reg >> FRAC_BITS);
        res_full.std_frac       = FRAC_OUT_W'(root_reg & R_W'(FMASK_N));
        res_full.empty_res      = 1'b0;
        res_full.count_overflow = ovf_reg;

        res_empty                = '0;
        res_empty.empty_res      = 1'b1;
        res_empty.count_overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_SQ;
            last_reg   <= 1'b0;
            ia_reg     <= '0;
            ib_reg     <= '0;
            la_reg     <= '0;
            lb_reg     <= '0;
            drain_reg  <= 1'b0;
            count_reg  <= '0;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        last_reg <= item.last;
                        if (take)
                        begin
                            count_reg <= count_reg + COUNT_BITS'(1);
                            sum_reg   <= sum_reg + {{(SUM_W-VAL_W){vbits[VAL_W-1]}}, vbits};
                            phase_reg <= PH_SQ;
                            ia_reg    <= '0;
                            ib_reg    <= '0;
                            la_reg    <= LIDX_W'(V_L - 1);
                            lb_reg    <= LIDX_W'(V_L - 1);
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            if (item.has_value)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            if (item.last)
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    if (ib_reg == lb_reg)
                    begin
                        ib_reg <= '0;
                        if (ia_reg == la_reg)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            ia_reg <= ia_reg + LIDX_W'(1);
                        end
                    end
                    else
                    begin
                        ib_reg <= ib_reg + LIDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!drain_reg)
                    begin
                        drain_reg <= 1'b1;
                    end
                    else
                    begin
                        drain_reg <= 1'b0;
                        ia_reg    <= '0;
                        ib_reg    <= '0;
                        unique case (phase_reg)
                            PH_SQ:
                            begin
                                state_reg <= last_reg ? S_FIN : S_IDLE;
                            end
                            PH_NN:
                            begin
                                phase_reg <= PH_NQ;
                                la_reg    <= LIDX_W'(Q_L - 1);
                                lb_reg    <= LIDX_W'(N_L - 1);
                                state_reg <= S_MUL;
                            end
                            PH_NQ:
                            begin
                                phase_reg <= PH_MM;
                                la_reg    <= LIDX_W'(MAG_L - 1);
                                lb_reg    <= LIDX_W'(MAG_L - 1);
                                state_reg <= S_MUL;
                            end
                            PH_MM:
                            begin
                                state_reg <= S_DIVX;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FIN:
                begin
                    if (count_reg == '0)
                    begin
                        result_reg <= res_empty;
                        done_reg   <= 1'b1;
                        ovf_reg    <= 1'b0;
                        sum_reg    <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        phase_reg <= PH_NN;
                        ia_reg    <= '0;
                        ib_reg    <= '0;
                        la_reg    <= LIDX_W'(N_L - 1);
                        lb_reg    <= LIDX_W'(N_L - 1);
                        state_reg <= S_MUL;
                    end
                end
                S_DIVX:
                begin
                    if (ust.done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (ust.done)
                    begin
                        state_reg <= S_DIVM;
                    end
                end
                S_DIVM:
                begin
                    if (ust.done)
                    begin
                        result_reg <= res_full;
                        done_reg   <= 1'b1;
                        count_reg  <= '0;
                        sum_reg    <= '0;
                        ovf_reg    <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            opa_reg <= OP_W'(vmag);
            opb_reg <= OP_W'(vmag);
            if (count_reg == '0)
            begin
                min_reg <= item.value;
                max_reg <= item.value;
            end
            else
            begin
                if (item.value < min_reg)
                begin
                    min_reg <= item.value;
                end
                if (item.value > max_reg)
                begin
                    max_reg <= item.value;
                end
            end
        end
        if (state_reg == S_FIN)
        begin
            q_reg   <= acc[SQ_W-1:0];
            mag_reg <= sum_abs[MAG_W-1:0];
            neg_reg <= sum_reg[SUM_W-1];
            opa_reg <= OP_W'(count_reg);
            opb_reg <= OP_W'(count_reg);
        end
        if ((state_reg == S_DRAIN) && drain_reg && (phase_reg == PH_NN))
        begin
            nsq_reg <= acc[DEN_W-1:0];
            opa_reg <= OP_W'(q_reg);
            opb_reg <= OP_W'(count_reg);
        end
        if ((state_reg == S_DRAIN) && drain_reg && (phase_reg == PH_NQ))
        begin
            opa_reg <= OP_W'(mag_reg);
            opb_reg <= OP_W'(mag_reg);
        end
        if ((state_reg == S_DIVX) && ust.done)
        begin
            x_reg <= wk;
        end
        if ((state_reg == S_SQRT) && ust.done)
        begin
            root_reg <= root;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_marker_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last && !item.has_value) |=> !busy)
        else $error("empty non-final transaction made the block busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.empty_res) |-> (result.count == '0 && result.total == '0))
        else $error("empty column result carries nonzero statistics");

    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !ust.busy)
        else $error("shift-subtract unit running while block idle");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the column statistics aggregator top level.
`timescale 1ns / 100ps

module testbench;
    import csa_pkg::*;

    typedef logic [399:0] wide_t;

    typedef struct {
        item_t   it;
        logic    typed;
        result_t res;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;

    logic [31:0]         col_count;
    logic signed [127:0] col_sum;
    logic [191:0]        col_sq;
    logic signed [63:0]  col_min;
    logic signed [63:0]  col_max;
    logic                col_ovf;

    result_t   stats_due[$];
    int        errors = 0;
    int        items_sent = 0;
    int        columns_seen = 0;
    int        idle_pct = 0;
    stim_row_t rows[$];

    localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;

    column_statistics_aggregator_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("FAIL column_statistics_aggregator_top");
        $finish;
    end

    function automatic void clear_column();
        col_count = '0;
        col_sum = '0;
        col_sq = '0;
        col_min = '0;
        col_max = '0;
        col_ovf = 1'b0;
    endfunction

    function automatic wide_t wide_isqrt(wide_t x);
        wide_t r;
        wide_t t;
        r = '0;
        for (int i = 140; i >= 0; i--)
        begin
            t = r | (wide_t'(1) << i);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic logic column_stats(item_t it, output result_t res);
        logic [64:0] mag_v;
        wide_t n, mag, num, mq, d, nn, vq, x, r;
        logic neg;
        res = '0;
        if (it.has_value)
        begin
            if (col_count != 32'hFFFF_FFFF)
            begin
                col_sum = col_sum + 128'(it.value);
                mag_v = it.value[63] ? -65'(it.value) : 65'(it.value);
                col_sq = col_sq + 192'(mag_v) * 192'(mag_v);
                if (col_count == 0)
                begin
                    col_min = it.value;
                    col_max = it.value;
                end
                else
                begin
                    if (it.value < col_min) col_min = it.value;
                    if (it.value > col_max) col_max = it.value;
                end
                col_count = col_count + 32'd1;
            end
            else
                col_ovf = 1'b1;
        end
        if (!it.last)
            return 1'b0;
        res.count = col_count;
        res.count_overflow = col_ovf;
        if (col_count == 0)
            res.empty_res = 1'b1;
        else
        begin
            n = wide_t'(col_count);
            neg = col_sum[127];
            mag = wide_t'(neg ? -col_sum : col_sum);
            mag = mag & ((wide_t'(1) << 128) - 1);
            num = mag << FRAC_BITS;
            if (neg)
                num = num + n - 1;
            mq = num / n;
            if (neg)
                mq = -mq;
            d = n * wide_t'(col_sq) - mag * mag;
            nn = n * n;
            vq = (d << FRAC_BITS) / nn;
            x = (d << (2 * FRAC_BITS)) / nn;
            r = wide_isqrt(x);
            res.total = col_sum[63:0];
            res.minimum = col_min;
            res.maximum = col_max;
            res.mean_int = mq[FRAC_BITS +: 64];
            res.mean_frac = mq[15:0];
            if (|vq[399:64+FRAC_BITS])
            begin
                res.var_int = '1;
                res.var_frac = '1;
            end
            else
            begin
                res.var_int = vq[FRAC_BITS +: 64];
                res.var_frac = vq[15:0];
            end
            res.std_int = r[FRAC_BITS +: 64];
            res.std_frac = r[15:0];
        end
        clear_column();
        return 1'b1;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (stats_due.size() == 0)
            begin
                $display("%0t: unexpected result transaction: expected none, actual %h",
                         $time, result);
                errors++;
            end
            else
            begin
                want = stats_due.pop_front();
                columns_seen++;
                check_field("count", 64'(want.count), 64'(result.count));
                check_field("total", want.total, result.total);
                check_field("minimum", want.minimum, result.minimum);
                check_field("maximum", want.maximum, result.maximum);
                check_field("mean_int", want.mean_int, result.mean_int);
                check_field("mean_frac", 64'(want.mean_frac), 64'(result.mean_frac));
                check_field("var_int", want.var_int, result.var_int);
                check_field("var_frac", 64'(want.var_frac), 64'(result.var_frac));
                check_field("std_int", want.std_int, result.std_int);
                check_field("std_frac", 64'(want.std_frac), 64'(result.std_frac));
                check_field("empty_res", 64'(want.empty_res), 64'(result.empty_res));
                check_field("count_overflow", 64'(want.count_overflow),
                            64'(result.count_overflow));
            end
        end
    end

    task automatic send_item(item_t it, logic typed, result_t typed_res);
        result_t res;
        logic got;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        got = column_stats(it, res);
        if (got)
            stats_due.push_back(typed ? typed_res : res);
    endtask

    function automatic logic signed [63:0] pick_value();
        case ($urandom_range(5))
            0: return VMAX;
            1: return VMIN;
            2: return 64'($signed($urandom_range(0, 200)) - 100);
            3: return {$urandom, $urandom};
            default: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(0, 62));
        endcase
    endfunction

    function automatic item_t mk_item(logic signed [63:0] v, logic h, logic l);
        item_t it;
        it.value = v;
        it.has_value = h;
        it.last = l;
        return it;
    endfunction

    function automatic void add_row(item_t it, logic typed, result_t res);
        stim_row_t row;
        row.it = it;
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endfunction

    initial
    begin
        result_t r0, r1;
        item_t it;
        int len;
        clear_column();

        r0 = '0;
        add_row(mk_item(64'sd0, 1'b0, 1'b1), 1'b1, '{count: 0, empty_res: 1, default: '0});
        add_row(mk_item(64'sd5, 1'b0, 1'b0), 1'b0, r0);
        add_row(mk_item(64'sd7, 1'b0, 1'b1), 1'b1, '{count: 0, empty_res: 1, default: '0});
        r1 = '0;
        r1.count = 1;
        r1.total = VMAX;
        r1.minimum = VMAX;
        r1.maximum = VMAX;
        r1.mean_int = VMAX;
        add_row(mk_item(VMAX, 1'b1, 1'b1), 1'b1, r1);
        r1.total = VMIN;
        r1.minimum = VMIN;
        r1.maximum = VMIN;
        r1.mean_int = VMIN;
        add_row(mk_item(VMIN, 1'b1, 1'b1), 1'b1, r1);
        add_row(mk_item(VMIN, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(VMAX, 1'b1, 1'b1), 1'b0, r0);
        add_row(mk_item(VMAX, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(VMAX, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(64'sd0, 1'b0, 1'b1), 1'b0, r0);
        add_row(mk_item(-64'sd1, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(64'sd0, 1'b0, 1'b0), 1'b0, r0);
        add_row(mk_item(64'sd0, 1'b1, 1'b1), 1'b0, r0);
        add_row(mk_item(64'sd1, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(64'sd2, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(64'sd4, 1'b1, 1'b1), 1'b0, r0);
        add_row(mk_item(-64'sd3, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(VMIN, 1'b1, 1'b0), 1'b0, r0);
        add_row(mk_item(-64'sd7, 1'b1, 1'b1), 1'b0, r0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].it, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 71 : (ph == 3) ? 28 : 0;
            for (int c = 0; c < 20; c++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 9);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(9) == 0)
                        send_item(mk_item({$urandom, $urandom}, 1'b0, 1'b0), 1'b0, r0);
                    send_item(mk_item(pick_value(), 1'b1, 1'b0), 1'b0, r0);
                end
                it = mk_item(pick_value(), 1'($urandom_range(1)), 1'b1);
                send_item(it, 1'b0, r0);
                if (ph == 2 && c == 8)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (stats_due.size() != 0)
                        @(posedge clk);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d transactions, checked %0d column results", items_sent, columns_seen);
        $display("Covered empty columns, extremes, saturated variance and idle phases");
        if (errors == 0)
            $display("PASS column_statistics_aggregator_top");
        else
            $display("FAIL column_statistics_aggregator_top");
        $finish;
    end
endmodule

// File: column_statistics_aggregator_top.f
design/csa_pkg.sv
design/csa_mac.sv
design/csa_shsub.sv
design/column_statistics_aggregator_top.sv
verif/testbench.sv
